/* rtl/core/height_map_2x2_reduce_macros.svh */
// Assertion macros for the 2x2 height map reduction block.
`ifndef HEIGHT_MAP_2X2_REDUCE_MACROS_SVH
`define HEIGHT_MAP_2X2_REDUCE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define HM2R_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define HM2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HM2R_ASSERT_NOW(label, clk, rst, ante, cons)
`define HM2R_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/hm2r_pkg.sv */
// Package: constants and register map of the 2x2 height map reduction block.
package hm2r_pkg;
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int SAMPLE_W = 16;
   localparam int PAIR_W   = 17;
   localparam int SUM_W    = 18;
   localparam int CFG_W    = 12;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_HALF_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;
   localparam logic [1:0] REG_REDUCE_MODE = 2'd2;

   localparam logic MODE_AVG = 1'b0;
   localparam logic MODE_MIN = 1'b1;

   localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 12'd2048;
   localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 12'd1024;
endpackage

/* rtl/core/height_map_2x2_reduce.sv */
// Top level: 2x2 box reduction of a signed 16-bit height map with a line store.
// Takes one raster sample per cycle with no bubbles unless a stalled result holds the input,
// and gives one result per 2x2 block, on the odd column of each odd input row, which passes
// through the read stage and then the output register.
// The line store is a single memory with at most one access per column pair: even
// rows write the pair value of each column pair, odd rows read it back and combine
// it with the new pair (sum divided by four toward zero, or minimum). A stalled
// result holds the read stage and, behind it, the input; otherwise the input keeps
// flowing while a result waits in the output register.
module height_map_2x2_reduce #(
   parameter int MAX_WIDTH  = hm2r_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = hm2r_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hm2r_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hm2r_pkg::SAMPLE_W-1:0] rsp_reduced,
   output logic                                rsp_row_end,
   output logic                                rsp_image_end,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hm2r_pkg::ADDR_W-1:0]         paddr,
   input  logic [hm2r_pkg::DATA_W-1:0]         pwdata,
   output logic [hm2r_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);
   import hm2r_pkg::*;

   `include "height_map_2x2_reduce_macros.svh"

   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int CW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int EXW = ((CW > RW) ? ((CW > CFG_W) ? CW : CFG_W)
                                   : ((RW > CFG_W) ? RW : CFG_W)) + 1;
   localparam logic [EXW-1:0] CAP_W = EXW'(MAX_WIDTH / 2);
   localparam logic [EXW-1:0] CAP_H = EXW'(MAX_HEIGHT / 2);

   // configuration registers
   logic [CFG_W-1:0] half_width_ff;
   logic [CFG_W-1:0] half_height_ff;
   logic             reduce_mode_ff;
   logic             cfg_write;

   // counters and left sample
   logic [CW-1:0]              col_count_ff, col_count_in;
   logic [RW-1:0]              row_count_ff, row_count_in;
   logic signed [SAMPLE_W-1:0] left_ff;

   // line store and read stage
   logic signed [PAIR_W-1:0]   pair_mem [STORE_DEPTH];
   logic signed [PAIR_W-1:0]   mem_rd_ff;
   logic                       s1_valid_ff;
   logic signed [PAIR_W-1:0]   s1_pair_ff;
   logic                       s1_row_end_ff;
   logic                       s1_img_end_ff;

   // output register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_reduced_ff;
   logic                       out_row_end_ff;
   logic                       out_img_end_ff;

   logic [EXW-1:0]             eff_w, eff_h, last_col_x, last_row_x;
   logic [CW-1:0]              last_col, col;
   logic [RW-1:0]              last_row, row;
   logic                       col_end, img_row_end;
   logic [CW-1:0]              col_half;
   logic [SW-1:0]              slot;
   logic                       accept, adv_out, do_write, do_read;
   logic signed [PAIR_W-1:0]   pair;
   logic signed [SUM_W-1:0]    total, total_adj;
   logic signed [SAMPLE_W-1:0] result;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_WIDTH_RST;
         half_height_ff <= HALF_HEIGHT_RST;
         reduce_mode_ff <= MODE_AVG;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_HALF_WIDTH:  half_width_ff  <= pwdata[CFG_W-1:0];
            REG_HALF_HEIGHT: half_height_ff <= pwdata[CFG_W-1:0];
            REG_REDUCE_MODE: reduce_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_HALF_WIDTH:  prdata = DATA_W'(half_width_ff);
         REG_HALF_HEIGHT: prdata = DATA_W'(half_height_ff);
         REG_REDUCE_MODE: prdata = DATA_W'(reduce_mode_ff);
         default:         prdata = '0;
      endcase
   end

   // image geometry: zero or oversized sizes fall back to the maximum
   always_comb begin
      eff_w = (half_width_ff == '0 || EXW'(half_width_ff) > CAP_W) ? CAP_W
                                                                 : EXW'(half_width_ff);
      eff_h = (half_height_ff == '0 || EXW'(half_height_ff) > CAP_H) ? CAP_H
                                                                   : EXW'(half_height_ff);
      last_col_x = (eff_w << 1) - EXW'(1);
      last_row_x = (eff_h << 1) - EXW'(1);
      last_col   = last_col_x[CW-1:0];
      last_row   = last_row_x[RW-1:0];
      col_end     = col_count_ff >= last_col;
      img_row_end = row_count_ff >= last_row;
      col = col_end ? last_col : col_count_ff;
      row = img_row_end ? last_row : row_count_ff;
      col_half = col >> 1;
      slot     = col_half[SW-1:0];
   end

   // handshake: a stalled result holds the read stage, and that holds the input
   assign adv_out   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !adv_out;
   assign accept    = req_valid && !req_stall;
   assign do_write  = accept && col[0] && !row[0];
   assign do_read   = accept && col[0] && row[0];

   always_comb begin
      if (reduce_mode_ff == MODE_MIN) begin
         pair = (left_ff < req_sample) ? PAIR_W'(left_ff) : PAIR_W'(req_sample);
      end else begin
         pair = PAIR_W'(left_ff) + PAIR_W'(req_sample);
      end
   end

   always_comb begin
      if (col_end) begin
         col_count_in = '0;
         row_count_in = img_row_end ? '0 : row + RW'(1);
      end else begin
         col_count_in = col + CW'(1);
         row_count_in = row_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         left_ff      <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (!col[0]) begin
            left_ff <= req_sample;
         end
      end
   end

   // line store: one write on even rows, one read on odd rows
   always_ff @(posedge clock) begin
      if (do_write) begin
         pair_mem[slot] <= pair;
      end
      if (do_read) begin
         mem_rd_ff <= pair_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (do_read) begin
         s1_valid_ff <= 1'b1;
      end else if (adv_out) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         s1_pair_ff    <= pair;
         s1_row_end_ff <= col_end;
         s1_img_end_ff <= col_end && img_row_end;
      end
   end

   // final combine: divide by four toward zero, or take the minimum
   always_comb begin
      total     = SUM_W'(mem_rd_ff) + SUM_W'(s1_pair_ff);
      total_adj = total + (total[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
      if (reduce_mode_ff == MODE_MIN) begin
         result = (mem_rd_ff < s1_pair_ff) ? mem_rd_ff[SAMPLE_W-1:0]
                                           : s1_pair_ff[SAMPLE_W-1:0];
      end else begin
         result = total_adj[SUM_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv_out) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && s1_valid_ff) begin
         out_reduced_ff <= result;
         out_row_end_ff <= s1_row_end_ff;
         out_img_end_ff <= s1_img_end_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_reduced   = out_reduced_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_image_end = out_img_end_ff;

   `HM2R_ASSERT_NOW(a_image_end_on_row_end, clock, reset,
      rsp_valid && rsp_image_end, rsp_row_end)
   `HM2R_ASSERT_NEXT(a_odd_pair_reaches_read_stage, clock, reset,
      do_read, s1_valid_ff)
   `HM2R_ASSERT_NEXT(a_read_stage_holds_on_stall, clock, reset,
      s1_valid_ff && out_valid_ff && rsp_stall, s1_valid_ff && $stable(mem_rd_ff))
endmodule
